>>> rtl/core/svpw_pkg.sv
package svpw_pkg;

   localparam int PAGE_WORDS     = 5;
   localparam int WORD_W         = 16;
   localparam int OFFSET_W       = 4;
   localparam int COUNT_W        = 4;
   localparam int STATUS_W       = 2;
   localparam int CSR_IDX_W      = 1;
   localparam int LANE_W         = $clog2(PAGE_WORDS);

   localparam int DEFAULT_MIN_US = 1000;
   localparam int DEFAULT_MAX_US = 2000;

   localparam logic [WORD_W-1:0] RST_MIN_US   = WORD_W'(DEFAULT_MIN_US);
   localparam logic [WORD_W-1:0] RST_MAX_US   = WORD_W'(DEFAULT_MAX_US);
   localparam logic [WORD_W-1:0] RST_PULSE_US =
      WORD_W'(((DEFAULT_MIN_US % 65536) + (DEFAULT_MAX_US % 65536)) / 2);
   localparam logic [WORD_W-1:0] RST_FLOOR_US   = WORD_W'(500);
   localparam logic [WORD_W-1:0] RST_CEILING_US = WORD_W'(2500);

   // page word positions
   localparam logic [LANE_W-1:0] PG_ENABLE = LANE_W'(0);
   localparam logic [LANE_W-1:0] PG_MIN    = LANE_W'(1);
   localparam logic [LANE_W-1:0] PG_MAX    = LANE_W'(2);
   localparam logic [LANE_W-1:0] PG_PULSE  = LANE_W'(3);
   localparam logic [LANE_W-1:0] PG_SLEW   = LANE_W'(4);

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [OFFSET_W-1:0]         offset;
      logic [COUNT_W-1:0]          count;
      word_type [PAGE_WORDS-1:0]   words;
      logic                        holds_wire;
   } req_type;

   typedef struct packed {
      logic     enable;
      word_type min_us;
      word_type max_us;
      word_type pulse_us;
      word_type slew;
   } page_type;

   typedef struct packed {
      word_type floor_us;
      word_type ceiling_us;
   } limits_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      page_type            page;
   } result_type;

endpackage

>>> rtl/core/svpw_csr.sv
module svpw_csr
   import svpw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  word_type             csr_wdata,
   output limits_type           limits
);

   limits_type limits_ff, limits_in;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FLOOR:   limits_in.floor_us   = csr_wdata;
            CSR_CEILING: limits_in.ceiling_us = csr_wdata;
            default:     limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.floor_us   <= RST_FLOOR_US;
         limits_ff.ceiling_us <= RST_CEILING_US;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

>>> rtl/core/svpw_eval.sv
module svpw_eval
   import svpw_pkg::*;
(
   input  req_type    req,
   input  page_type   page,
   input  limits_type limits,
   output result_type result
);

   logic [PAGE_WORDS-1:0]  wr;
   word_type [PAGE_WORDS-1:0] val;
   logic [OFFSET_W:0]      span;
   logic                   bad_range;
   logic                   bad_value;
   logic                   not_armed;
   page_type               stored;
   page_type               swapped;

   // route each burst word to its page word
   always_comb begin
      logic [OFFSET_W-1:0] diff;
      for (int p = 0; p < PAGE_WORDS; p++) begin
         diff   = OFFSET_W'(p) - req.offset;
         wr[p]  = (req.offset <= OFFSET_W'(p)) && (diff < OFFSET_W'(req.count));
         val[p] = wr[p] ? req.words[diff[LANE_W-1:0]] : '0;
      end
   end

   assign span      = {1'b0, req.offset} + {1'b0, req.count};
   assign bad_range = span > (OFFSET_W+1)'(PAGE_WORDS);

   assign bad_value =
      (wr[PG_MIN] && (val[PG_MIN] < limits.floor_us || val[PG_MIN] > limits.ceiling_us)) ||
      (wr[PG_MAX] && (val[PG_MAX] < limits.floor_us || val[PG_MAX] > limits.ceiling_us)) ||
      (wr[PG_ENABLE] && val[PG_ENABLE] > WORD_W'(1));

   assign not_armed = wr[PG_ENABLE] && (val[PG_ENABLE] != '0) && !req.holds_wire;

   always_comb begin
      stored.enable   = wr[PG_ENABLE] ? val[PG_ENABLE][0] : page.enable;
      stored.min_us   = wr[PG_MIN]    ? val[PG_MIN]       : page.min_us;
      stored.max_us   = wr[PG_MAX]    ? val[PG_MAX]       : page.max_us;
      stored.pulse_us = wr[PG_PULSE]  ? val[PG_PULSE]     : page.pulse_us;
      stored.slew     = wr[PG_SLEW]   ? val[PG_SLEW]      : page.slew;

      swapped = stored;
      if (stored.min_us > stored.max_us) begin
         swapped.min_us = stored.max_us;
         swapped.max_us = stored.min_us;
      end
      // limits are ordered now, so clamp both ways
      if (swapped.pulse_us < swapped.min_us) begin
         swapped.pulse_us = swapped.min_us;
      end else if (swapped.pulse_us > swapped.max_us) begin
         swapped.pulse_us = swapped.max_us;
      end
   end

   always_comb begin
      result.page = page;
      priority if (bad_range) begin
         result.status = ST_BAD_RANGE;
      end else if (bad_value) begin
         result.status = ST_BAD_VALUE;
      end else if (not_armed) begin
         result.status = ST_NOT_ARMED;
      end else begin
         result.status = ST_OK;
         result.page   = swapped;
      end
   end

endmodule

>>> rtl/core/servo_register_page_write.sv
// channel | direction | handshake        | payload
// req     | in        | req_valid/stall  | offset, count, word0..word4, holds_wire
// rsp     | out       | rsp_valid/stall  | status, enable_out, min_out, max_out,
//         |           |                  | pulse_out, slew_out
// csr     | in        | csr_we           | csr_index, csr_wdata
//
// One word per cycle sustained while rsp is not stalled; an accepted word goes
// into the input register, then through evaluation into the result register,
// whose content shows on rsp.
// The page register is updated in the same cycle as the result register.
// Reset restores the default page and limits and empties both stages.
// A stalled result holds; req stalls only when both stages are full.
module servo_register_page_write
   import svpw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [OFFSET_W-1:0]  req_offset,
   input  logic [COUNT_W-1:0]   req_count,
   input  word_type             req_word0,
   input  word_type             req_word1,
   input  word_type             req_word2,
   input  word_type             req_word3,
   input  word_type             req_word4,
   input  logic                 req_holds_wire,

   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_enable_out,
   output word_type             rsp_min_out,
   output word_type             rsp_max_out,
   output word_type             rsp_pulse_out,
   output word_type             rsp_slew_out,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  word_type             csr_wdata
);

   limits_type limits;
   req_type    req_ff, req_in;
   logic       req_vld_ff, req_vld_in;
   page_type   page_ff, page_in;
   result_type res_ff, res_in;
   result_type eval_res;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;
   logic       take;

   svpw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .limits    (limits)
   );

   svpw_eval u_eval (
      .req    (req_ff),
      .page   (page_ff),
      .limits (limits),
      .result (eval_res)
   );

   assign advance   = req_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = req_vld_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      req_in = req_ff;
      if (take) begin
         req_in.offset     = req_offset;
         req_in.count      = req_count;
         req_in.words      = {req_word4, req_word3, req_word2, req_word1, req_word0};
         req_in.holds_wire = req_holds_wire;
      end
      req_vld_in = take || (req_vld_ff && !advance);

      page_in    = advance ? eval_res.page : page_ff;
      res_in     = advance ? eval_res : res_ff;
      // drop the result once taken unless a new one replaces it
      rsp_vld_in = advance || (rsp_vld_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff       <= 1'b0;
         rsp_vld_ff       <= 1'b0;
         page_ff.enable   <= 1'b0;
         page_ff.min_us   <= RST_MIN_US;
         page_ff.max_us   <= RST_MAX_US;
         page_ff.pulse_us <= RST_PULSE_US;
         page_ff.slew     <= '0;
      end else begin
         req_vld_ff <= req_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         page_ff    <= page_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = res_ff.status;
   assign rsp_enable_out = res_ff.page.enable;
   assign rsp_min_out    = res_ff.page.min_us;
   assign rsp_max_out    = res_ff.page.max_us;
   assign rsp_pulse_out  = res_ff.page.pulse_us;
   assign rsp_slew_out   = res_ff.page.slew;

   a_refusal_keeps_page: assert property (@(posedge clock) disable iff (reset)
      (advance && eval_res.status != ST_OK) |=> (page_ff == $past(page_ff)))
      else $error("refused word changed the page");

   a_limits_ordered: assert property (@(posedge clock) disable iff (reset)
      page_ff.min_us <= page_ff.max_us)
      else $error("page limits inverted");

   a_pulse_clamped: assert property (@(posedge clock) disable iff (reset)
      (page_ff.pulse_us >= page_ff.min_us) && (page_ff.pulse_us <= page_ff.max_us))
      else $error("pulse outside limits");

   a_result_matches_page: assert property (@(posedge clock) disable iff (reset)
      advance |=> (res_ff.page == page_ff))
      else $error("result page differs from stored page");

   a_pending_word_kept: assert property (@(posedge clock) disable iff (reset)
      (req_vld_ff && !advance) |=> (req_vld_ff && req_ff == $past(req_ff)))
      else $error("pending word lost");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import svpw_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [OFFSET_W-1:0]  req_offset = '0;
   logic [COUNT_W-1:0]   req_count = '0;
   word_type             req_word0 = '0;
   word_type             req_word1 = '0;
   word_type             req_word2 = '0;
   word_type             req_word3 = '0;
   word_type             req_word4 = '0;
   logic                 req_holds_wire = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_enable_out;
   word_type             rsp_min_out;
   word_type             rsp_max_out;
   word_type             rsp_pulse_out;
   word_type             rsp_slew_out;

   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   word_type             csr_wdata = '0;

   // predicted page and limit registers
   word_type page_words[PAGE_WORDS] = '{16'd0, WORD_W'(DEFAULT_MIN_US), WORD_W'(DEFAULT_MAX_US),
                                        WORD_W'((DEFAULT_MIN_US + DEFAULT_MAX_US) / 2), 16'd0};
   word_type floor_now = 16'd500;
   word_type ceil_now  = 16'd2500;

   result_type expected_pages[$];

   int fail_count    = 0;
   int cycle_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_ticket   = 0;

   servo_register_page_write DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_offset     (req_offset),
      .req_count      (req_count),
      .req_word0      (req_word0),
      .req_word1      (req_word1),
      .req_word2      (req_word2),
      .req_word3      (req_word3),
      .req_word4      (req_word4),
      .req_holds_wire (req_holds_wire),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_enable_out (rsp_enable_out),
      .rsp_min_out    (rsp_min_out),
      .rsp_max_out    (rsp_max_out),
      .rsp_pulse_out  (rsp_pulse_out),
      .rsp_slew_out   (rsp_slew_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("servo_register_page_write verification failed");
         $finish;
      end
   end

   // Apply one burst to the predicted page and return the word it should produce.
   function automatic result_type apply_page_write(input req_type b);
      result_type          r;
      logic [STATUS_W-1:0] status;
      int                  slot;
      word_type            w;
      word_type            held;
      status = ST_OK;
      if (int'(b.offset) + int'(b.count) > PAGE_WORDS) begin
         status = ST_BAD_RANGE;
      end else begin
         for (int i = 0; i < b.count; i++) begin
            slot = b.offset + i;
            w = b.words[i];
            if ((slot == PG_MIN || slot == PG_MAX) && (w < floor_now || w > ceil_now))
               status = ST_BAD_VALUE;
            if (slot == PG_ENABLE && w > 16'd1)
               status = ST_BAD_VALUE;
         end
         if (status == ST_OK) begin
            for (int i = 0; i < b.count; i++) begin
               if (b.offset + i == PG_ENABLE && b.words[i] != 16'd0 && !b.holds_wire)
                  status = ST_NOT_ARMED;
            end
         end
         if (status == ST_OK) begin
            for (int i = 0; i < b.count; i++)
               page_words[b.offset + i] = b.words[i];
            // swap and clamp run even for an empty burst
            if (page_words[PG_MIN] > page_words[PG_MAX]) begin
               held = page_words[PG_MIN];
               page_words[PG_MIN] = page_words[PG_MAX];
               page_words[PG_MAX] = held;
            end
            if (page_words[PG_PULSE] < page_words[PG_MIN])
               page_words[PG_PULSE] = page_words[PG_MIN];
            if (page_words[PG_PULSE] > page_words[PG_MAX])
               page_words[PG_PULSE] = page_words[PG_MAX];
         end
      end
      r.status        = status;
      r.page.enable   = page_words[PG_ENABLE][0];
      r.page.min_us   = page_words[PG_MIN];
      r.page.max_us   = page_words[PG_MAX];
      r.page.pulse_us = page_words[PG_PULSE];
      r.page.slew     = page_words[PG_SLEW];
      return r;
   endfunction

   function automatic req_type page_burst(input int offset, input int count,
                                          input word_type w0, input word_type w1,
                                          input word_type w2, input word_type w3,
                                          input word_type w4, input logic may);
      req_type b;
      b.offset     = OFFSET_W'(offset);
      b.count      = COUNT_W'(count);
      b.words[0]   = w0;
      b.words[1]   = w1;
      b.words[2]   = w2;
      b.words[3]   = w3;
      b.words[4]   = w4;
      b.holds_wire = may;
      return b;
   endfunction

   function automatic word_type corner_word();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h0001;
         2: return floor_now - 16'd1;
         3: return floor_now;
         4: return ceil_now;
         5: return ceil_now + 16'd1;
         6: return 16'hFFFF;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Well-formed bursts fit the page and carry plausible values; the rest is noise.
   function automatic req_type make_burst(input bit well_formed);
      req_type b;
      int      slot;
      if (!well_formed) begin
         b.offset     = OFFSET_W'($urandom_range(0, 15));
         b.count      = COUNT_W'($urandom_range(0, 15));
         b.holds_wire = 1'($urandom_range(0, 1));
         for (int i = 0; i < PAGE_WORDS; i++)
            b.words[i] = $urandom_range(0, 1) ? corner_word() : word_type'($urandom);
         return b;
      end
      b.count      = COUNT_W'($urandom_range(0, PAGE_WORDS));
      b.offset     = OFFSET_W'($urandom_range(0, PAGE_WORDS - b.count));
      b.holds_wire = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < PAGE_WORDS; i++) begin
         slot = b.offset + i;
         if (i >= b.count)
            b.words[i] = word_type'($urandom);
         else if ($urandom_range(0, 19) == 0)
            b.words[i] = corner_word();
         else if (slot == PG_ENABLE)
            b.words[i] = word_type'($urandom_range(0, 1));
         else if (slot == PG_MIN || slot == PG_MAX)
            b.words[i] = word_type'($urandom_range(ceil_now, floor_now));
         else if (slot == PG_PULSE && $urandom_range(0, 1))
            b.words[i] = word_type'($urandom_range(0, 3000));
         else
            b.words[i] = word_type'($urandom);
      end
      return b;
   endfunction

   // Offer one word, hold it until taken, then record the predicted page.
   task automatic send_burst(input req_type b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_offset     <= b.offset;
      req_count      <= b.count;
      req_word0      <= b.words[0];
      req_word1      <= b.words[1];
      req_word2      <= b.words[2];
      req_word3      <= b.words[3];
      req_word4      <= b.words[4];
      req_holds_wire <= b.holds_wire;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_pages.push_back(apply_page_write(b));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pages.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      @(posedge clock);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input word_type value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_FLOOR)
         floor_now = value;
      else
         ceil_now = value;
   endtask

   task automatic set_limits(input word_type lo, input word_type hi);
      drain_results();
      write_register(CSR_FLOOR, lo);
      write_register(CSR_CEILING, hi);
   endtask

   task automatic test_directed_bursts();
      set_idling(6, 6);
      send_burst(page_burst(0, 0, 0, 0, 0, 0, 0, 1'b0));
      send_burst(page_burst(5, 0, 0, 0, 0, 0, 0, 1'b0));
      send_burst(page_burst(15, 0, 0, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(0, 15, 1, 1000, 2000, 1500, 3, 1'b1));
      send_burst(page_burst(15, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
      send_burst(page_burst(3, 3, 1, 2, 3, 4, 5, 1'b1));
      send_burst(page_burst(0, 5, 1, 1200, 1800, 1500, 7, 1'b1));
      send_burst(page_burst(0, 1, 1, 0, 0, 0, 0, 1'b0));
      send_burst(page_burst(0, 1, 0, 0, 0, 0, 0, 1'b0));
      send_burst(page_burst(0, 1, 2, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(0, 1, 16'hFFFF, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 1, 499, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 1, 500, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(2, 1, 2500, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(2, 1, 2501, 0, 0, 0, 0, 1'b1));
      // inverted limits get swapped
      send_burst(page_burst(1, 2, 2400, 600, 0, 0, 0, 1'b1));
      send_burst(page_burst(3, 1, 0, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(3, 1, 16'hFFFF, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(4, 1, 16'hFFFF, 0, 0, 0, 0, 1'b1));
      // a bad limit is reported ahead of a missing arm
      send_burst(page_burst(0, 2, 1, 0, 0, 0, 0, 1'b0));
      send_burst(page_burst(0, 3, 1, 1000, 900, 0, 0, 1'b0));
      send_burst(page_burst(2, 3, 700, 16'hFFFF, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 1, 2500, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(4, 1, 0, 0, 0, 0, 0, 1'b1));
      drain_results();
   endtask

   task automatic test_register_extremes();
      set_idling(0, 0);
      // floor above ceiling refuses every limit word
      set_limits(3000, 100);
      send_burst(page_burst(1, 1, 2000, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(2, 1, 100, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 0, 0, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(3, 2, 5, 9, 0, 0, 0, 1'b1));
      set_limits(0, 16'hFFFF);
      send_burst(page_burst(1, 2, 0, 16'hFFFF, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 2, 16'hFFFF, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(0, 4, 1, 40000, 20000, 100, 0, 1'b1));
      set_limits(1234, 1234);
      send_burst(page_burst(1, 2, 1234, 1234, 0, 0, 0, 1'b1));
      send_burst(page_burst(1, 1, 1233, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(2, 1, 1235, 0, 0, 0, 0, 1'b1));
      set_limits(16'hFFFF, 0);
      send_burst(page_burst(1, 1, 0, 0, 0, 0, 0, 1'b1));
      send_burst(page_burst(2, 1, 16'hFFFF, 0, 0, 0, 0, 1'b1));
      set_limits(500, 2500);
      drain_results();
   endtask

   task automatic test_backpressure_fill();
      set_idling(0, 0);
      // start a long receiver hold-off, then keep offering so the block backs up
      hold_ticket++;
      for (int i = 0; i < 16; i++)
         send_burst(make_burst(1'b1));
      drain_results();
   endtask

   task automatic test_sender_pause();
      set_idling(6, 6);
      for (int round = 0; round < 5; round++) begin
         for (int i = 0; i < 3; i++)
            send_burst(make_burst(1'b1));
         drain_results();
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(75, 0);
            2: set_idling(0, 75);
            3: set_idling(6, 6);
            4: set_idling(0, 0);
            default: set_idling(6, 6);
         endcase
         if (phase == 4)
            set_limits(0, 16'hFFFF);
         else
            set_limits(word_type'($urandom_range(0, 1500)),
                       word_type'($urandom_range(1500, 65535)));
         for (int i = 0; i < 145; i++)
            send_burst(make_burst($urandom_range(0, 99) < 85));
      end
      drain_results();
   endtask

   // receiver: random stall, or a long hold-off when one is requested
   always @(negedge clock) begin : receiver
      int hold_served;
      int hold_left;
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pages.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want = expected_pages.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("enable_out", want.page.enable, rsp_enable_out);
            compare_field("min_out", want.page.min_us, rsp_min_out);
            compare_field("max_out", want.page.max_us, rsp_max_out);
            compare_field("pulse_out", want.page.pulse_us, rsp_pulse_out);
            compare_field("slew_out", want.page.slew, rsp_slew_out);
         end
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed_bursts();
      test_register_extremes();
      test_backpressure_fill();
      test_sender_pause();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("servo_register_page_write verification clean");
      else
         $display("servo_register_page_write verification failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/svpw_pkg.sv
rtl/core/svpw_csr.sv
rtl/core/svpw_eval.sv
rtl/core/servo_register_page_write.sv
tb/tb.sv
